FILE: design/wqws_pkg.sv
// wqws_pkg: shared types and codes of the wait queue wakeup select block
// no dependencies; imported by every other file of the block

package wqws_pkg;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 6;
    localparam int PRI_W    = 8;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [ID_W-1:0]     t_proc;
    typedef logic [PRI_W-1:0]    t_pri;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_ADD    = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_WAKE   = 2'd2;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_FULL   = 2'd1;
    localparam t_status ST_ABSENT = 2'd2;

    typedef struct packed {
        t_proc proc;
        t_pri  pri;
    } t_entry;

    typedef struct packed {
        logic id_hit;
        logic pri_gt;
    } t_cmp;

endpackage

FILE: design/wqws_if.sv
// wqws_req_if / wqws_rsp_if: valid-ready channels of the wait queue block
// depends on wqws_pkg

interface wqws_req_if import wqws_pkg::*; ();
    logic  valid;
    logic  ready;
    t_cmd  command;
    t_proc proc_id;
    t_pri  priority_req;

    modport source (output valid, command, proc_id, priority_req, input ready);
    modport sink   (input valid, command, proc_id, priority_req, output ready);
    modport monitor (input valid, ready, command, proc_id, priority_req);
endinterface

interface wqws_rsp_if import wqws_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    woken_valid;
    t_proc   woken_id;
    t_count  waiting_count;
    t_status status;

    modport source (output valid, woken_valid, woken_id, waiting_count, status,
                    input ready);
    modport sink   (input valid, woken_valid, woken_id, waiting_count, status,
                    output ready);
    modport monitor (input valid, ready, woken_valid, woken_id, waiting_count, status);
endinterface

FILE: design/wqws_store.sv
// wqws_store: entry memory of the wait list, one write and one read port
// read data is registered; depends on wqws_pkg

module wqws_store import wqws_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/wqws_cmp.sv
// wqws_cmp: shared compare unit, tests one entry against the id key
// and against the best priority seen so far; depends on wqws_pkg

module wqws_cmp import wqws_pkg::*; (
    input  t_entry i_entry,
    input  t_proc  i_key_id,
    input  t_pri   i_best_pri,
    output t_cmp   o_res
);

    assign o_res.id_hit = (i_entry.proc == i_key_id);
    assign o_res.pri_gt = (i_entry.pri > i_best_pri);

endmodule

FILE: design/wait_queue_wakeup_select.sv
// wait_queue_wakeup_select: wait list of process ids with add, remove and wakeup
// depends on wqws_pkg, wqws_if, wqws_store, wqws_cmp
//
// usage:
//   i_req carries one command beat (command, proc_id, priority_req); o_rsp
//   returns exactly one result beat per command (woken_valid, woken_id,
//   waiting_count, status). i_cfg_we / i_cfg_wdata write the discipline bit
//   (0 first in first out, 1 highest priority first); the user must write it
//   only while the block is idle, the block itself does not enforce this.
//   one command is worked on at a time; i_req.ready is low until it is done.
//   add, a command on an empty list and the unused code go from accept straight
//   to the done state, which loads the result beat into the output register.
//   remove / wakeup: a scan of the stored entries through the single read
//   port, one entry a cycle, then compaction of the later entries through the
//   same port, one entry a cycle. first-in-first-out wakeup stops its scan
//   after the head entry. the result sits in an output register; a new
//   command is taken while it waits, and a finished command holds until the
//   receiver takes the beat. reset (synchronous, active low) empties the list
//   and sets the discipline to first in first out; no clearing pass,
//   the entry memory is not cleared.

module wait_queue_wakeup_select import wqws_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    wqws_req_if.sink    i_req,
    wqws_rsp_if.source  o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_dk, n_dk;
    logic          r_dv, n_dv;
    logic [CW-1:0] r_pick, n_pick;
    t_pri          r_best, n_best;
    t_proc         r_woken, n_woken;
    logic          r_wv, n_wv;
    t_cmd          r_cmd, n_cmd;
    t_proc         r_id, n_id;
    t_status       r_status, n_status;
    logic          r_disc;

    logic          r_o_valid;
    logic          r_o_wv;
    t_proc         r_o_wid;
    t_count        r_o_cnt;
    t_status       r_o_status;

    logic          w_accept;
    logic          w_load;
    logic          w_last;
    logic          w_take;
    logic          w_more;
    logic [CW-1:0] w_pick;
    logic [CW-1:0] w_wr_pos;
    logic [CW+COUNT_W-1:0] w_cnt_ext;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_wdata;
    t_entry        w_rd_data;
    t_cmp          w_cmp;

    wqws_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_we),
        .i_wr_addr (w_waddr),
        .i_wr_data (w_wdata),
        .i_rd_addr (r_k[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    wqws_cmp u_cmp (
        .i_entry    (w_rd_data),
        .i_key_id   (r_id),
        .i_best_pri (r_best),
        .o_res      (w_cmp)
    );

    assign i_req.ready = (r_state == S_IDLE) && i_rst_n;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_load      = (r_state == S_DONE) && (!r_o_valid || o_rsp.ready);
    assign w_last      = (r_dk == (r_cnt - CW'(1)));
    assign w_take      = (r_dk == '0) || w_cmp.pri_gt;
    assign w_pick      = w_take ? r_dk : r_pick;
    assign w_more      = (r_k < r_cnt);
    assign w_wr_pos    = r_dk - CW'(1);
    assign w_cnt_ext   = {{COUNT_W{1'b0}}, r_cnt};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_dk     = r_dk;
        n_dv     = r_dv;
        n_pick   = r_pick;
        n_best   = r_best;
        n_woken  = r_woken;
        n_wv     = r_wv;
        n_cmd    = r_cmd;
        n_id     = r_id;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = i_req.command;
                    n_id     = i_req.proc_id;
                    n_status = ST_OK;
                    n_wv     = 1'b0;
                    n_woken  = '0;
                    n_k      = '0;
                    n_dv     = 1'b0;
                    n_state  = S_DONE;
                    case (i_req.command)
                        CMD_ADD: begin
                            if (r_cnt >= CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_cnt[AW-1:0];
                                w_wdata = '{proc: i_req.proc_id, pri: i_req.priority_req};
                                n_cnt   = r_cnt + CW'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_cnt == '0) begin
                                n_status = ST_ABSENT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_WAKE: begin
                            if (r_cnt != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_k  = r_k + CW'(1);
                n_dv = 1'b1;
                n_dk = r_k;
                if (r_dv) begin
                    if (r_cmd == CMD_REMOVE) begin
                        if (w_cmp.id_hit) begin
                            n_pick  = r_dk;
                            n_k     = r_dk + CW'(1);
                            n_dv    = 1'b0;
                            n_state = S_SHIFT;
                        end else if (w_last) begin
                            n_status = ST_ABSENT;
                            n_state  = S_DONE;
                        end
                    end else if (!r_disc) begin
                        n_pick  = '0;
                        n_woken = w_rd_data.proc;
                        n_wv    = 1'b1;
                        n_k     = CW'(1);
                        n_dv    = 1'b0;
                        n_state = S_SHIFT;
                    end else begin
                        n_pick = w_pick;
                        if (w_take) begin
                            n_best  = w_rd_data.pri;
                            n_woken = w_rd_data.proc;
                        end
                        if (w_last) begin
                            n_wv    = 1'b1;
                            n_k     = w_pick + CW'(1);
                            n_dv    = 1'b0;
                            n_state = S_SHIFT;
                        end
                    end
                end
            end
            S_SHIFT: begin
                n_dv = w_more;
                n_dk = r_k;
                if (w_more) begin
                    n_k = r_k + CW'(1);
                end
                if (r_dv) begin
                    w_we    = 1'b1;
                    w_waddr = w_wr_pos[AW-1:0];
                    w_wdata = w_rd_data;
                end
                if (!w_more && !r_dv) begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_dv    <= 1'b0;
            r_disc  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_dv    <= n_dv;
            if (i_cfg_we) begin
                r_disc <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dk     <= n_dk;
        r_pick   <= n_pick;
        r_best   <= n_best;
        r_woken  <= n_woken;
        r_wv     <= n_wv;
        r_cmd    <= n_cmd;
        r_id     <= n_id;
        r_status <= n_status;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_wv     <= r_wv;
            r_o_wid    <= r_wv ? r_woken : '0;
            r_o_cnt    <= w_cnt_ext[COUNT_W-1:0];
            r_o_status <= r_status;
        end
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.woken_valid   = r_o_wv;
    assign o_rsp.woken_id      = r_o_wid;
    assign o_rsp.waiting_count = r_o_cnt;
    assign o_rsp.status        = r_o_status;

endmodule

FILE: design/wqws_checker.sv
// wqws_checker: port-level assertions for wait_queue_wakeup_select
// depends on wqws_pkg; bound to the top level below

module wqws_checker import wqws_pkg::*; #(
    parameter int DEPTH = 16
) (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_req_valid,
    input logic    i_req_ready,
    input logic    i_rsp_valid,
    input logic    i_rsp_ready,
    input logic    i_woken_valid,
    input t_proc   i_woken_id,
    input t_count  i_waiting_count,
    input t_status i_status
);

    localparam logic [6:0] DEPTH_W = 7'(DEPTH);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result beat dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_woken_id)
            && $stable(i_waiting_count) && $stable(i_status)
            && $stable(i_woken_valid))
        else $error("result beat changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("new command taken while one is in work");

    a_woken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_woken_valid |-> i_woken_id == '0)
        else $error("woken id set without a woken process");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == ST_FULL
            |-> !i_woken_valid && i_waiting_count == DEPTH_W[4:0])
        else $error("full status with wrong waiter count");

endmodule

bind wait_queue_wakeup_select wqws_checker #(.DEPTH(DEPTH)) u_wqws_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_woken_valid   (o_rsp.woken_valid),
    .i_woken_id      (o_rsp.woken_id),
    .i_waiting_count (o_rsp.waiting_count),
    .i_status        (o_rsp.status)
);
